### sv/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared codes, character classes and item types for the expression checker
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int ESC_MAX_DEPTH = 255;
    localparam int ESC_MAX_LEN   = 4096;
    localparam int COUNT_W       = 13;

    // comment filter phases
    localparam logic [2:0] CM_NONE       = 3'd0;
    localparam logic [2:0] CM_SLASH      = 3'd1;
    localparam logic [2:0] CM_LINE       = 3'd2;
    localparam logic [2:0] CM_BLOCK      = 3'd3;
    localparam logic [2:0] CM_BLOCK_STAR = 3'd4;

    // lexer phases
    localparam logic [2:0] LX_IDLE   = 3'd0;
    localparam logic [2:0] LX_ID     = 3'd1;
    localparam logic [2:0] LX_INT    = 3'd2;
    localparam logic [2:0] LX_DOT    = 3'd3;
    localparam logic [2:0] LX_FRAC   = 3'd4;
    localparam logic [2:0] LX_BADNUM = 3'd5;
    localparam logic [2:0] LX_LT     = 3'd6;

    // token kinds
    localparam logic [2:0] TK_OPERAND = 3'd0;
    localparam logic [2:0] TK_OPEN    = 3'd1;
    localparam logic [2:0] TK_CLOSE   = 3'd2;
    localparam logic [2:0] TK_BINOP   = 3'd3;
    localparam logic [2:0] TK_BAD     = 3'd4;

    // verdicts
    localparam logic [1:0] V_PENDING = 2'd0;
    localparam logic [1:0] V_ACCEPT  = 2'd1;
    localparam logic [1:0] V_LEX     = 2'd2;
    localparam logic [1:0] V_SYNTAX  = 2'd3;

    // characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } esc_item_t;

    typedef struct packed {
        logic      en;
        esc_item_t item;
    } esc_step_t;

    typedef struct packed {
        logic [1:0]         verdict;
        logic [COUNT_W-1:0] matched_chars;
    } esc_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

### sv/esc_core.sv
// ----------------------------------------------------------------------------
// esc_core
// comment filter, lexer and grammar state, one character per step
// ----------------------------------------------------------------------------
module esc_core
    import esc_pkg::*;
#(
    parameter int MAX_DEPTH = ESC_MAX_DEPTH,
    parameter int MAX_LEN   = ESC_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  esc_step_t   step,
    output esc_result_t res
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int CAP_I   = (MAX_LEN < 8191) ? MAX_LEN : 8191;
    localparam logic [COUNT_W:0]   CAP_WIDE = (COUNT_W + 1)'(CAP_I);
    localparam logic [COUNT_W-1:0] CAP      = COUNT_W'(CAP_I);
    localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(MAX_DEPTH);

    typedef struct packed {
        logic [2:0]         cm;
        logic [2:0]         lx;
        logic [COUNT_W-1:0] tl;
        logic               eo;
        logic [DEPTH_W-1:0] pd;
        logic [1:0]         vr;
        logic [COUNT_W-1:0] mc;
    } st_t;

    localparam st_t ST_RESET = '{cm: CM_NONE, lx: LX_IDLE, tl: '0, eo: 1'b0,
                                 pd: '0, vr: V_PENDING, mc: '0};

    st_t state_reg;
    st_t state_next;
    st_t work;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > CAP_WIDE) ? CAP : s[COUNT_W-1:0];
    endfunction

    function automatic st_t apply_token(input st_t s, input logic [2:0] kind,
                                        input logic [COUNT_W-1:0] len);
        st_t r;
        r = s;
        if (r.vr != V_PENDING) return r;
        if (!r.eo) begin
            if (kind == TK_OPERAND) begin
                r.mc = sat_add(r.mc, len);
                r.eo = 1'b1;
            end else if (kind == TK_OPEN) begin
                if (r.pd == DEPTH_TOP) begin
                    r.vr = V_SYNTAX;
                end else begin
                    r.pd = r.pd + 1'b1;
                    r.mc = sat_add(r.mc, COUNT_W'(1));
                end
            end else begin
                r.vr = V_SYNTAX;
            end
        end else begin
            if (kind == TK_BINOP) begin
                r.mc = sat_add(r.mc, len);
                r.eo = 1'b0;
            end else if (kind == TK_CLOSE) begin
                if (r.pd != '0) begin
                    r.pd = r.pd - 1'b1;
                    r.mc = sat_add(r.mc, COUNT_W'(1));
                end else begin
                    r.vr = V_SYNTAX;
                end
            end else if (kind == TK_BAD) begin
                r.vr = V_LEX;
            end else begin
                r.vr = V_SYNTAX;
            end
        end
        return r;
    endfunction

    function automatic st_t finish_pending(input st_t s);
        st_t r;
        r = s;
        r.lx = LX_IDLE;
        if (s.lx == LX_ID || s.lx == LX_INT || s.lx == LX_FRAC)
            r = apply_token(r, TK_OPERAND, s.tl);
        else if (s.lx == LX_DOT || s.lx == LX_BADNUM)
            r = apply_token(r, TK_BAD, '0);
        else if (s.lx == LX_LT)
            r = apply_token(r, TK_BINOP, COUNT_W'(1));
        r.tl = '0;
        return r;
    endfunction

    function automatic st_t start_token(input st_t s, input logic [7:0] c);
        st_t r;
        r = s;
        r.tl = '0;
        if (is_digit(c)) begin
            r.lx = LX_INT;
            r.tl = COUNT_W'(1);
        end else if (is_alpha(c)) begin
            r.lx = LX_ID;
            r.tl = COUNT_W'(1);
        end else if (c == CH_LT) begin
            r.lx = LX_LT;
        end else if (c == CH_EQ || c == CH_PLUS || c == CH_STAR) begin
            r = apply_token(r, TK_BINOP, COUNT_W'(1));
        end else if (c == CH_LPAREN) begin
            r = apply_token(r, TK_OPEN, COUNT_W'(1));
        end else if (c == CH_RPAREN) begin
            r = apply_token(r, TK_CLOSE, COUNT_W'(1));
        end else begin
            r = apply_token(r, TK_BAD, '0);
        end
        return r;
    endfunction

    function automatic st_t lex_char(input st_t s, input logic [7:0] c);
        st_t r;
        r = s;
        unique case (r.lx) inside
            LX_ID: begin
                if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                    r.tl = sat_add(r.tl, COUNT_W'(1));
                    return r;
                end
            end
            LX_INT, LX_DOT, LX_FRAC, LX_BADNUM: begin
                if (is_digit(c)) begin
                    if (r.lx == LX_DOT) r.lx = LX_FRAC;
                    r.tl = sat_add(r.tl, COUNT_W'(1));
                    return r;
                end
                if (c == CH_DOT) begin
                    r.lx = (r.lx == LX_INT) ? LX_DOT : LX_BADNUM;
                    r.tl = sat_add(r.tl, COUNT_W'(1));
                    return r;
                end
            end
            LX_LT: begin
                if (c == CH_EQ) begin
                    r.lx = LX_IDLE;
                    r.tl = '0;
                    r = apply_token(r, TK_BINOP, COUNT_W'(2));
                    return r;
                end
            end
            default: begin
            end
        endcase
        r = finish_pending(r);
        if (r.vr == V_PENDING) r = start_token(r, c);
        return r;
    endfunction

    function automatic st_t filter_char(input st_t s, input logic [7:0] c);
        st_t r;
        r = s;
        unique case (r.cm)
            CM_NONE: begin
                if (c == CH_SLASH) r.cm = CM_SLASH;
                else if (c != CH_SPACE) r = lex_char(r, c);
            end
            CM_SLASH: begin
                if (c == CH_SLASH) begin
                    r.cm = CM_LINE;
                end else if (c == CH_STAR) begin
                    r.cm = CM_BLOCK_STAR;
                end else begin
                    r.cm = CM_NONE;
                    r = lex_char(r, CH_SLASH);
                    if (c != CH_SPACE && r.vr == V_PENDING) r = lex_char(r, c);
                end
            end
            CM_LINE: begin
            end
            CM_BLOCK: begin
                if (c == CH_STAR) r.cm = CM_BLOCK_STAR;
            end
            default: begin
                if (c == CH_SLASH) r.cm = CM_NONE;
                else if (c != CH_STAR) r.cm = CM_BLOCK;
            end
        endcase
        return r;
    endfunction

    function automatic st_t end_statement(input st_t s);
        st_t r;
        r = s;
        if (r.vr == V_PENDING && r.cm == CM_SLASH) r = lex_char(r, CH_SLASH);
        if (r.vr == V_PENDING) r = finish_pending(r);
        if (r.vr == V_PENDING) begin
            if (!r.eo || r.pd != '0) r.vr = V_SYNTAX;
            else r.vr = V_ACCEPT;
        end
        return r;
    endfunction

    always_comb begin
        work = state_reg;
        if (step.item.has_char && state_reg.vr == V_PENDING)
            work = filter_char(work, step.item.char_code);
        if (step.item.last)
            work = end_statement(work);
        res.verdict       = work.vr;
        res.matched_chars = work.mc;
        state_next = step.item.last ? ST_RESET : work;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RESET;
        end else if (step.en) begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/expression_syntax_checker.sv
// ----------------------------------------------------------------------------
// expression_syntax_checker
// streaming syntax check of one expression statement per tlast-framed run
// ----------------------------------------------------------------------------
//   channel | dir | tdata                  | tuser      | tlast
//   s_      | in  | char_code[7:0]         | has_char   | end of statement
//   m_      | out | verdict, done, matched | -          | -
//
// one character per cycle if m_tready high; result via input reg, then result reg
// the throughput is set by the combinational lexer and grammar update in esc_core
// synchronous reset clears the parse state; it also returns to reset after tlast
// m_tready low holds the result register, then the input register, then s_tready
// ----------------------------------------------------------------------------
module expression_syntax_checker
    import esc_pkg::*;
#(
    parameter int MAX_DEPTH = ESC_MAX_DEPTH,
    parameter int MAX_LEN   = ESC_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic [0:0]  s_tuser,   // has_char[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // verdict[1:0], done_res[2], matched_chars[15:3]
);

    logic        in_vld_reg;
    esc_item_t   in_item_reg;
    logic        out_vld_reg;
    logic [15:0] out_data_reg;
    logic        advance;
    esc_step_t   step;
    esc_result_t core_res;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign step.en   = advance;
    assign step.item = in_item_reg;

    esc_core #(
        .MAX_DEPTH(MAX_DEPTH),
        .MAX_LEN  (MAX_LEN)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (step),
        .res    (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) in_vld_reg <= s_tvalid;
            if (advance) out_vld_reg <= 1'b1;
            else if (m_tready) out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.char_code <= s_tdata;
            in_item_reg.has_char  <= s_tuser[0];
            in_item_reg.last      <= s_tlast;
        end
        if (advance) begin
            out_data_reg <= {core_res.matched_chars, (core_res.verdict != V_PENDING),
                             core_res.verdict};
        end
    end

    a_last_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.last) |-> (core_res.verdict != V_PENDING))
        else $error("statement end left verdict pending");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_vld_reg)
        else $error("accepted transaction not held in input register");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed transaction produced no result");

endmodule
